[sv/rcd_pkg.sv]
`default_nettype none
package rcd_pkg;

    localparam int MAX_BYTES_DEF = 8;

    localparam int CODE_W       = 7;
    localparam int RAW_W        = 8;
    localparam int ID_W         = 4;
    localparam int VALUE_W      = 8;
    localparam int BYTE_COUNT_W = 4;
    localparam int CH2_LEN      = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int Q_DEPTH      = 2;
    localparam int Q_AW         = 1;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [ID_W-1:0]   t_id;

    localparam t_code CODE_DATA_LIM = 7'h40;
    localparam t_code CODE_ACK      = 7'd64;
    localparam t_code CODE_NACK     = 7'd65;
    localparam t_code CODE_RESV     = 7'd66;
    localparam t_code CODE_INV      = 7'd67;

    localparam t_id ADDR_HIGH_RST = 4'd1;
    localparam t_id ADDR_LOW_RST  = 4'd2;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADDR_HIGH = 1'b0,
        REG_ADDR_LOW  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_op   op;
        t_code code;
    } t_qitem;

    typedef struct packed {
        logic [BYTE_COUNT_W-1:0]          byte_count;
        logic                             all_bytes_valid;
        logic                             ch1_valid;
        t_id                              ch1_id;
        logic [VALUE_W-1:0]               ch1_value;
        logic                             ch2_valid;
        logic [CH2_LEN-1:0][CODE_W-1:0]   ch2_value;
    } t_result;

    localparam t_code CI = CODE_INV;
    localparam t_code CA = CODE_ACK;
    localparam t_code CN = CODE_NACK;
    localparam t_code CR = CODE_RESV;

    // 4-of-8 decode table, indexed by the received byte.
    localparam t_code DEC_TABLE [256] = '{
        CI, CI, CI, CI, CI, CI, CI, CI,  CI, CI, CI, CI, CI, CI, CI, CA,
        CI, CI, CI, CI, CI, CI, CI, 7'h33, CI, CI, CI, 7'h34, CI, 7'h35, 7'h36, CI,
        CI, CI, CI, CI, CI, CI, CI, 7'h3a, CI, CI, CI, 7'h3b, CI, 7'h3c, 7'h37, CI,
        CI, CI, CI, 7'h3f, CI, 7'h3d, 7'h38, CI, CI, 7'h3e, 7'h39, CI, CN, CI, CI, CI,
        CI, CI, CI, CI, CI, CI, CI, 7'h24, CI, CI, CI, 7'h23, CI, 7'h22, 7'h21, CI,
        CI, CI, CI, 7'h1f, CI, 7'h1e, 7'h20, CI, CI, 7'h1d, 7'h1c, CI, 7'h1b, CI, CI, CI,
        CI, CI, CI, 7'h19, CI, 7'h18, 7'h1a, CI, CI, 7'h17, 7'h16, CI, 7'h15, CI, CI, CI,
        CI, 7'h25, 7'h14, CI, 7'h13, CI, CI, CI, 7'h32, CI, CI, CI, CI, CI, CI, CI,
        CI, CI, CI, CI, CI, CI, CI, CR,  CI, CI, CI, 7'h0e, CI, 7'h0d, 7'h0c, CI,
        CI, CI, CI, 7'h0a, CI, 7'h09, 7'h0b, CI, CI, 7'h08, 7'h07, CI, 7'h06, CI, CI, CI,
        CI, CI, CI, 7'h04, CI, 7'h03, 7'h05, CI, CI, 7'h02, 7'h01, CI, 7'h00, CI, CI, CI,
        CI, 7'h0f, 7'h10, CI, 7'h11, CI, CI, CI, 7'h12, CI, CI, CI, CI, CI, CI, CI,
        CI, CI, CI, CR, CI, 7'h2b, 7'h30, CI, CI, 7'h2a, 7'h2f, CI, 7'h31, CI, CI, CI,
        CI, 7'h29, 7'h2e, CI, 7'h2d, CI, CI, CI, 7'h2c, CI, CI, CI, CI, CI, CI, CI,
        CI, CR, 7'h28, CI, 7'h27, CI, CI, CI, 7'h26, CI, CI, CI, CI, CI, CI, CI,
        CA, CI, CI, CI, CI, CI, CI, CI,  CI, CI, CI, CI, CI, CI, CI, CI
    };

endpackage
`default_nettype wire

[sv/rcd_in_if.sv]
`default_nettype none
interface rcd_in_if;
    import rcd_pkg::*;

    logic             valid;
    logic             ready;
    logic             operation;
    logic [RAW_W-1:0] raw_byte;

    modport source (output valid, output operation, output raw_byte, input ready);
    modport sink   (input valid, input operation, input raw_byte, output ready);
endinterface
`default_nettype wire

[sv/rcd_out_if.sv]
`default_nettype none
interface rcd_out_if;
    import rcd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BYTE_COUNT_W-1:0] byte_count;
    logic                    all_bytes_valid;
    logic                    ch1_valid;
    logic [ID_W-1:0]         ch1_id;
    logic [VALUE_W-1:0]      ch1_value;
    logic                    ch2_valid;
    logic [CODE_W-1:0]       ch2_value0;
    logic [CODE_W-1:0]       ch2_value1;
    logic [CODE_W-1:0]       ch2_value2;
    logic [CODE_W-1:0]       ch2_value3;
    logic [CODE_W-1:0]       ch2_value4;
    logic [CODE_W-1:0]       ch2_value5;

    modport source (
        output valid, output byte_count, output all_bytes_valid, output ch1_valid,
        output ch1_id, output ch1_value, output ch2_valid, output ch2_value0,
        output ch2_value1, output ch2_value2, output ch2_value3, output ch2_value4,
        output ch2_value5, input ready
    );
    modport sink (
        input valid, input byte_count, input all_bytes_valid, input ch1_valid,
        input ch1_id, input ch1_value, input ch2_valid, input ch2_value0,
        input ch2_value1, input ch2_value2, input ch2_value3, input ch2_value4,
        input ch2_value5, output ready
    );
endinterface
`default_nettype wire

[sv/rcd_front.sv]
`default_nettype none
module rcd_front (
    rcd_in_if.sink          i_in,
    output logic            o_push_valid,
    output rcd_pkg::t_qitem o_push_item,
    input  logic            i_push_ready
);
    import rcd_pkg::*;

    // The byte is decoded on the way into the queue; the code of an
    // end-of-window item is never looked at.
    always_comb begin
        i_in.ready       = i_push_ready;
        o_push_valid     = i_in.valid;
        o_push_item.op   = t_op'(i_in.operation);
        o_push_item.code = DEC_TABLE[i_in.raw_byte];
    end
endmodule
`default_nettype wire

[sv/rcd_queue.sv]
`default_nettype none
module rcd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  rcd_pkg::t_qitem i_push_item,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output rcd_pkg::t_qitem o_pop_item,
    input  logic            i_pop_ready
);
    import rcd_pkg::*;

    t_qitem          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            push, pop;

    always_comb begin
        o_push_ready = (r_cnt != (Q_AW+1)'(Q_DEPTH));
        o_pop_valid  = (r_cnt != '0);
        o_pop_item   = r_mem[r_rd_ptr];
        push         = i_push_valid && o_push_ready;
        pop          = o_pop_valid && i_pop_ready;
        // The depth is a power of two, so the pointers wrap on their own.
        n_wr_ptr     = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr     = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt        = r_cnt + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end
endmodule
`default_nettype wire

[sv/rcd_back.sv]
`default_nettype none
module rcd_back #(
    parameter int MAX_BYTES = rcd_pkg::MAX_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rcd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_q_valid,
    input  rcd_pkg::t_qitem                 i_q_item,
    output logic                            o_q_ready,
    rcd_out_if.source                       o_out
);
    import rcd_pkg::*;

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int SW = $clog2(MAX_BYTES);

    t_code         r_store [MAX_BYTES];
    logic [CW-1:0] r_count;
    logic          r_clean;
    t_id           r_addr_high;
    t_id           r_addr_low;
    logic          r_out_valid;
    t_result       r_res, n_res;

    logic          is_end, take, has_room;
    logic          ch1_ok, ch2_ok;
    t_id           id0;
    logic [CW-1:0] ch2_need;

    always_comb begin
        is_end    = (i_q_item.op == OP_END);
        // Bytes never wait; only a result needs the output register free.
        o_q_ready = !is_end || !r_out_valid || o_out.ready;
        take      = i_q_valid && o_q_ready;
        has_room  = (r_count < CW'(MAX_BYTES));
    end

    always_comb begin
        id0    = r_store[0][5:2];
        ch1_ok = (r_count >= CW'(2)) && (r_store[0] < CODE_DATA_LIM)
                 && (r_store[1] < CODE_DATA_LIM)
                 && ((id0 == r_addr_high) || (id0 == r_addr_low));
        ch2_need = ch1_ok ? CW'(CH2_LEN + 2) : CW'(CH2_LEN);
        ch2_ok   = (r_count == ch2_need);
        n_res    = '0;
        for (int k = 0; k < CH2_LEN; k++) begin
            n_res.ch2_value[k] = ch1_ok ? r_store[k+2] : r_store[k];
            if (n_res.ch2_value[k] == CODE_INV) begin
                ch2_ok = 1'b0;
            end
        end
        if (!ch2_ok) begin
            n_res.ch2_value = '0;
        end
        n_res.ch2_valid       = ch2_ok;
        n_res.byte_count      = BYTE_COUNT_W'(r_count);
        n_res.all_bytes_valid = r_clean;
        n_res.ch1_valid       = ch1_ok;
        n_res.ch1_id          = ch1_ok ? id0 : '0;
        n_res.ch1_value       = ch1_ok ? {r_store[0][1:0], r_store[1][5:0]} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clean     <= 1'b1;
            r_addr_high <= ADDR_HIGH_RST;
            r_addr_low  <= ADDR_LOW_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_ADDR_HIGH: r_addr_high <= i_cfg_data;
                    REG_ADDR_LOW:  r_addr_low  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (take && is_end) begin
                r_count <= '0;
                r_clean <= 1'b1;
            end else if (take && has_room) begin
                r_count <= r_count + 1'b1;
                if (i_q_item.code == CODE_INV) begin
                    r_clean <= 1'b0;
                end
            end
            if (take && is_end) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !is_end && has_room) begin
            r_store[r_count[SW-1:0]] <= i_q_item.code;
        end
        if (take && is_end) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        o_out.valid           = r_out_valid;
        o_out.byte_count      = r_res.byte_count;
        o_out.all_bytes_valid = r_res.all_bytes_valid;
        o_out.ch1_valid       = r_res.ch1_valid;
        o_out.ch1_id          = r_res.ch1_id;
        o_out.ch1_value       = r_res.ch1_value;
        o_out.ch2_valid       = r_res.ch2_valid;
        o_out.ch2_value0      = r_res.ch2_value[0];
        o_out.ch2_value1      = r_res.ch2_value[1];
        o_out.ch2_value2      = r_res.ch2_value[2];
        o_out.ch2_value3      = r_res.ch2_value[3];
        o_out.ch2_value4      = r_res.ch2_value[4];
        o_out.ch2_value5      = r_res.ch2_value[5];
    end
endmodule
`default_nettype wire

[sv/railcom_cutout_decoder.sv]
`default_nettype none
// Channel   Dir  Contents                                        Items
// i_in      in   operation, raw_byte                             one per byte or window end
// o_out     out  byte_count, all_bytes_valid, ch1_*, ch2_*       one per window end
// i_cfg_*   in   write enable, register index, 4-bit data        addr_high_id, addr_low_id
//
// One item is taken every cycle while the queue has room; bytes are decoded by table
// lookup on entry and stored into a register file one per cycle in the back end.
// A result is registered at the edge its end item leaves the two-entry queue, so o_out.valid
// rises at the earliest once the end item has passed the queue entry and the result register.
// While a result waits on o_out, further bytes are still taken; only a second window end
// waits, and the queue then fills and drops i_in.ready.
// Reset clears the byte count and the output valid, sets the clean-window flag, and loads the IDs 1 and 2.
module railcom_cutout_decoder #(
    parameter int MAX_BYTES = rcd_pkg::MAX_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rcd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rcd_in_if.sink                          i_in,
    rcd_out_if.source                       o_out
);
    import rcd_pkg::*;

    logic   push_valid, push_ready;
    t_qitem push_item;
    logic   pop_valid, pop_ready;
    t_qitem pop_item;

    rcd_front u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    rcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    rcd_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (pop_valid),
        .i_q_item   (pop_item),
        .o_q_ready  (pop_ready),
        .o_out      (o_out)
    );
endmodule
`default_nettype wire

[sv/rcd_checker.sv]
`default_nettype none
module rcd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [3:0] i_byte_count,
    input  logic       i_all_bytes_valid,
    input  logic       i_ch1_valid,
    input  logic [3:0] i_ch1_id,
    input  logic [7:0] i_ch1_value,
    input  logic       i_ch2_valid,
    input  logic [6:0] i_ch2_value0,
    input  logic [6:0] i_ch2_value1,
    input  logic [6:0] i_ch2_value2,
    input  logic [6:0] i_ch2_value3,
    input  logic [6:0] i_ch2_value4,
    input  logic [6:0] i_ch2_value5
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
        && $stable({i_byte_count, i_all_bytes_valid, i_ch1_valid, i_ch1_id, i_ch1_value,
                    i_ch2_valid, i_ch2_value0, i_ch2_value1, i_ch2_value2,
                    i_ch2_value3, i_ch2_value4, i_ch2_value5}))
        else $error("result changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_ch1_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ch1_valid |-> i_ch1_id == 4'd0 && i_ch1_value == 8'd0)
        else $error("channel 1 fields not cleared");

    a_ch2_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ch2_valid |-> i_ch2_value0 == 7'd0 && i_ch2_value1 == 7'd0
        && i_ch2_value2 == 7'd0 && i_ch2_value3 == 7'd0 && i_ch2_value4 == 7'd0
        && i_ch2_value5 == 7'd0)
        else $error("channel 2 fields not cleared");

    a_ch2_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ch2_valid |->
        (i_ch1_valid && i_byte_count == 4'd8) || (!i_ch1_valid && i_byte_count == 4'd6))
        else $error("channel 2 valid with wrong byte count");
endmodule

bind railcom_cutout_decoder rcd_checker u_rcd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_byte_count      (o_out.byte_count),
    .i_all_bytes_valid (o_out.all_bytes_valid),
    .i_ch1_valid       (o_out.ch1_valid),
    .i_ch1_id          (o_out.ch1_id),
    .i_ch1_value       (o_out.ch1_value),
    .i_ch2_valid       (o_out.ch2_valid),
    .i_ch2_value0      (o_out.ch2_value0),
    .i_ch2_value1      (o_out.ch2_value1),
    .i_ch2_value2      (o_out.ch2_value2),
    .i_ch2_value3      (o_out.ch2_value3),
    .i_ch2_value4      (o_out.ch2_value4),
    .i_ch2_value5      (o_out.ch2_value5)
);
`default_nettype wire
